### src/jarn_pkg.sv
// Package for the joint angle range normaliser: formats, codes and item types.
`timescale 1ns / 1ps
package jarn_pkg;

  localparam int ANGLE_W = 20;
  localparam int FRAC_W  = 14;
  localparam int NORM_W  = FRAC_W + 2;
  localparam int QUOT_W  = FRAC_W + 2;
  localparam int CNT_W   = $clog2(QUOT_W + 1);
  localparam int NLANES  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [ANGLE_W-1:0] ONE_Q = ANGLE_W'(1 << FRAC_W);
  localparam logic signed [ANGLE_W-1:0] RANGE_DEFAULT =
    ANGLE_W'(((157 << FRAC_W) + 50) / 100);
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_TOGGLE  = 2'd2,
    CMD_SPARE   = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CLAW_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAW_HIGH = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_START,
    ST_NORM
  } state_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [ANGLE_W-1:0] shoulder_raw;
    logic signed [ANGLE_W-1:0] upper_raw;
    logic signed [ANGLE_W-1:0] lower_raw;
    logic                      armed_level;
    logic                      offset_button_level;
    logic                      range_button_level;
  } in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]  norm_shoulder;
    logic signed [NORM_W-1:0]  norm_upper;
    logic signed [NORM_W-1:0]  norm_lower;
    logic signed [NORM_W-1:0]  norm_claw;
    logic signed [ANGLE_W-1:0] shoulder_angle;
    logic signed [ANGLE_W-1:0] upper_angle_neg;
    logic signed [ANGLE_W-1:0] lower_angle;
    logic                      armed;
    logic                      learning;
  } out_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } lane_stat_t;

endpackage

### src/jarn_lane.sv
// One normaliser lane: clamp, then restoring divide one quotient bit a cycle.
`timescale 1ns / 1ps
module jarn_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [jarn_pkg::ANGLE_W-1:0]  v,
  input  logic signed [jarn_pkg::ANGLE_W-1:0]  lo,
  input  logic signed [jarn_pkg::ANGLE_W-1:0]  hi,
  output jarn_pkg::lane_stat_t                 stat,
  output logic signed [jarn_pkg::NORM_W-1:0]   res
);
  localparam int A  = jarn_pkg::ANGLE_W;
  localparam int QW = jarn_pkg::QUOT_W;
  localparam int NW = A + QW + 1;

  logic                          busy_r, valid_r, empty_r;
  logic [jarn_pkg::CNT_W-1:0]    cnt_r;
  logic [A-1:0]                  num_r, den_r;
  logic [A+1:0]                  rem_r;
  logic [A:0]                    dv_r;
  logic [QW-1:0]                 nlo_r, q_r;
  logic signed [jarn_pkg::NORM_W-1:0] res_r;

  logic signed [A-1:0] vc;
  logic [NW-1:0]       n_full;
  logic [A+1:0]        rs;
  logic                ge;
  logic [A+1:0]        rem_nxt;
  logic [QW-1:0]       q_nxt;
  logic [QW:0]         q_off;

  always_comb begin
    vc = v;
    if (v < lo) vc = lo;
    if (vc > hi) vc = hi;
    n_full  = {num_r, {QW{1'b0}}} + NW'(den_r);
    rs      = {rem_r[A:0], nlo_r[QW-1]};
    ge      = rs >= {1'b0, dv_r};
    rem_nxt = ge ? (rs - {1'b0, dv_r}) : rs;
    q_nxt   = {q_r[QW-2:0], ge};
    q_off   = {1'b0, q_nxt} - (QW+1)'(jarn_pkg::ONE_Q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
      cnt_r   <= '0;
      empty_r <= lo >= hi;
      num_r   <= A'(vc - lo);
      den_r   <= A'(hi - lo);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        // remainder seeded with the top bits; below the divisor unless the range is empty
        rem_r <= (A+2)'(n_full[NW-1:QW]);
        nlo_r <= n_full[QW-1:0];
        dv_r  <= {den_r, 1'b0};
        q_r   <= '0;
        cnt_r <= cnt_r + 1'b1;
      end else begin
        rem_r <= rem_nxt;
        nlo_r <= {nlo_r[QW-2:0], 1'b0};
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == jarn_pkg::CNT_W'(QW)) begin
          busy_r  <= 1'b0;
          valid_r <= 1'b1;
          res_r   <= empty_r ? '0 : q_off[jarn_pkg::NORM_W-1:0];
        end
      end
    end
  end

  assign stat.busy  = busy_r;
  assign stat.valid = valid_r;
  assign res        = res_r;

  a_busy_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && valid_r)) else $error("lane busy and valid together");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("lane did not start");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= jarn_pkg::CNT_W'(QW)) else $error("lane count overrun");

endmodule

### src/joint_angle_range_normalizer_core.sv
// Top level: angle offsets, range tracking, four normaliser lanes and result register.
//
//  channel | ports                      | role
//  in      | in_valid in_ready in_data  | raw angles, buttons, command
//  out     | out_valid out_ready out_data | normalised channels and angles
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | claw range ends
//
// After an item is accepted it passes the angle stage, the lane load, the divider seed,
// the 16 quotient-bit steps and the result load into the output register.
// The next item can be accepted in the cycle after that load, so items never overlap.
// Reset (rst_n, synchronous) restores offsets, ranges, claw range and flags at once.
// A stalled result holds in the output register; cfg is always ready.
`timescale 1ns / 1ps
module joint_angle_range_normalizer_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  jarn_pkg::in_t                            in_data,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output jarn_pkg::out_t                           out_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [jarn_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic signed [jarn_pkg::ANGLE_W-1:0]      cfg_data
);
  localparam int A = jarn_pkg::ANGLE_W;

  jarn_pkg::state_t state_r, state_nxt;
  jarn_pkg::in_t    item_r;
  logic signed [A-1:0] ang_r [3];
  logic signed [A-1:0] uneg_r;
  logic signed [A-1:0] off_r [3], off_nxt [3];
  logic signed [A-1:0] lo_r [3], lo_nxt [3];
  logic signed [A-1:0] hi_r [3], hi_nxt [3];
  logic signed [A-1:0] claw_lo_r, claw_hi_r;
  logic learn_r, learn_nxt, offb_r, rngb_r;
  logic out_valid_r;
  jarn_pkg::out_t out_r;

  logic signed [A-1:0] raw [3];
  logic signed [A-1:0] ang_c [3];
  logic signed [A-1:0] uneg_c;
  logic signed [A:0]   diff [3];
  logic                lane_start, all_valid, any_busy, commit;
  logic                off_pr, rng_pr;
  jarn_pkg::lane_stat_t stat [jarn_pkg::NLANES];
  logic signed [jarn_pkg::NORM_W-1:0] nres [jarn_pkg::NLANES];

  assign raw[0] = item_r.shoulder_raw;
  assign raw[1] = item_r.upper_raw;
  assign raw[2] = item_r.lower_raw;

  // relative angles: shoulder quartered by arithmetic shift, others saturated
  always_comb begin
    for (int i = 0; i < 3; i++) diff[i] = {raw[i][A-1], raw[i]} - {off_r[i][A-1], off_r[i]};
    ang_c[0] = A'(diff[0] >>> 2);
    for (int i = 1; i < 3; i++) begin
      if (diff[i][A] != diff[i][A-1]) ang_c[i] = diff[i][A] ? jarn_pkg::ANGLE_MIN
                                                           : jarn_pkg::ANGLE_MAX;
      else ang_c[i] = diff[i][A-1:0];
    end
    uneg_c = (ang_c[1] == jarn_pkg::ANGLE_MIN) ? jarn_pkg::ANGLE_MAX : -ang_c[1];
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    jarn_lane u_lane (
      .clk(clk), .rst_n(rst_n), .start(lane_start),
      .v(ang_r[g]), .lo(lo_r[g]), .hi(hi_r[g]),
      .stat(stat[g]), .res(nres[g])
    );
  end
  jarn_lane u_claw (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .v('0), .lo(claw_lo_r), .hi(claw_hi_r),
    .stat(stat[3]), .res(nres[3])
  );

  always_comb begin
    all_valid = 1'b1;
    any_busy  = 1'b0;
    for (int i = 0; i < jarn_pkg::NLANES; i++) begin
      all_valid = all_valid & stat[i].valid;
      any_busy  = any_busy | stat[i].busy;
    end
  end

  // controller
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    lane_start = 1'b0;
    commit     = 1'b0;
    case (state_r)
      jarn_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = jarn_pkg::ST_ANGLE;
      end
      jarn_pkg::ST_ANGLE: state_nxt = jarn_pkg::ST_START;
      jarn_pkg::ST_START: begin
        lane_start = 1'b1;
        state_nxt  = jarn_pkg::ST_NORM;
      end
      jarn_pkg::ST_NORM: begin
        if (all_valid && !any_busy && (!out_valid_r || out_ready)) begin
          commit    = 1'b1;
          state_nxt = jarn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jarn_pkg::ST_IDLE;
    endcase
  end

  // state updates in item order: command, tracking, offset edge, range edge
  always_comb begin
    off_pr = !item_r.offset_button_level;
    rng_pr = !item_r.range_button_level;
    learn_nxt = learn_r;
    for (int i = 0; i < 3; i++) begin
      off_nxt[i] = off_r[i];
      lo_nxt[i]  = lo_r[i];
      hi_nxt[i]  = hi_r[i];
    end
    case (jarn_pkg::cmd_t'(item_r.cmd))
      jarn_pkg::CMD_CAPTURE: for (int i = 0; i < 3; i++) off_nxt[i] = raw[i];
      jarn_pkg::CMD_TOGGLE: begin
        learn_nxt = !learn_nxt;
        if (learn_nxt) for (int i = 0; i < 3; i++) begin
          lo_nxt[i] = ang_r[i];
          hi_nxt[i] = ang_r[i];
        end
      end
      default: ;
    endcase
    if (learn_nxt) for (int i = 0; i < 3; i++) begin
      if (ang_r[i] < lo_nxt[i]) lo_nxt[i] = ang_r[i];
      if (ang_r[i] > hi_nxt[i]) hi_nxt[i] = ang_r[i];
    end
    if (off_pr && !offb_r) for (int i = 0; i < 3; i++) off_nxt[i] = raw[i];
    if (rng_pr && !rngb_r) begin
      learn_nxt = !learn_nxt;
      if (learn_nxt) for (int i = 0; i < 3; i++) begin
        lo_nxt[i] = ang_r[i];
        hi_nxt[i] = ang_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jarn_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      learn_r     <= 1'b0;
      offb_r      <= 1'b0;
      rngb_r      <= 1'b0;
      claw_lo_r   <= -jarn_pkg::ONE_Q;
      claw_hi_r   <= jarn_pkg::ONE_Q;
      for (int i = 0; i < 3; i++) begin
        off_r[i] <= '0;
        lo_r[i]  <= -jarn_pkg::RANGE_DEFAULT;
        hi_r[i]  <= jarn_pkg::RANGE_DEFAULT;
      end
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) item_r <= in_data;
      if (state_r == jarn_pkg::ST_ANGLE) begin
        for (int i = 0; i < 3; i++) ang_r[i] <= ang_c[i];
        uneg_r <= uneg_c;
      end
      if (cfg_valid) begin
        if (cfg_index == jarn_pkg::CFG_CLAW_LOW)  claw_lo_r <= cfg_data;
        if (cfg_index == jarn_pkg::CFG_CLAW_HIGH) claw_hi_r <= cfg_data;
      end
      if (commit) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (commit) begin
        learn_r     <= learn_nxt;
        offb_r      <= off_pr;
        rngb_r      <= rng_pr;
        for (int i = 0; i < 3; i++) begin
          off_r[i] <= off_nxt[i];
          lo_r[i]  <= lo_nxt[i];
          hi_r[i]  <= hi_nxt[i];
        end
        out_r.norm_shoulder   <= nres[0];
        out_r.norm_upper      <= nres[1];
        out_r.norm_lower      <= nres[2];
        out_r.norm_claw       <= nres[3];
        out_r.shoulder_angle  <= ang_r[0];
        out_r.upper_angle_neg <= uneg_r;
        out_r.lower_angle     <= ang_r[2];
        out_r.armed           <= !item_r.armed_level;
        out_r.learning        <= learn_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  a_idle_lanes_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !any_busy) else $error("item taken while lanes busy");
  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && out_r.learning == learn_r)
    else $error("result not loaded with learning flag");
  a_accept_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == jarn_pkg::ST_ANGLE)
    else $error("accepted item not in angle stage");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_ready)) else $error("result overwritten");

endmodule

### sim/testbench.sv
// Testbench for the joint angle range normaliser: directed table, random items, checker.
`timescale 1ns / 1ps
module testbench;

  localparam int AW = jarn_pkg::ANGLE_W;
  localparam int NW = jarn_pkg::NORM_W;
  localparam int FW = jarn_pkg::FRAC_W;
  localparam int IW = jarn_pkg::CFG_IDX_W;
  localparam logic [IW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [IW-1:0] CFG_SPARE_B = 2'd3;

  localparam int ITEMS_PER_PHASE = 220;
  localparam int NUM_PHASES      = 5;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 600000;
  localparam longint SAT_HI      = 524287;
  localparam longint SAT_LO      = -524288;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  jarn_pkg::in_t  in_data;
  jarn_pkg::out_t out_data;
  logic [IW-1:0]        cfg_index;
  logic signed [AW-1:0] cfg_data;

  joint_angle_range_normalizer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint offs [3];
  longint lows [3];
  longint highs [3];
  bit     learn_on, off_was, rng_was;
  longint claw_lo, claw_hi;

  jarn_pkg::out_t norm_q [$];
  int     mismatches;
  int     cycles;
  int     results_seen;
  bit     calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    calm <= (cycles > 8000 && cycles < 14000);
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint sat(longint v);
    return (v > SAT_HI) ? SAT_HI : (v < SAT_LO) ? SAT_LO : v;
  endfunction

  function automatic longint scale_to_unit(longint v, longint lo, longint hi);
    longint num, den;
    if (lo >= hi) return 0;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    num = v - lo;
    den = hi - lo;
    return ((num << (FW + 2)) + den) / (2 * den) - (longint'(1) << FW);
  endfunction

  function automatic void restart_ranges(longint a [3]);
    for (int i = 0; i < 3; i++) begin
      lows[i]  = a[i];
      highs[i] = a[i];
    end
  endfunction

  function automatic jarn_pkg::out_t normalise_item(jarn_pkg::in_t d);
    longint raw [3];
    longint ang [3];
    longint n [4];
    jarn_pkg::out_t r;
    bit     off_p, rng_p;
    raw[0] = longint'(d.shoulder_raw);
    raw[1] = longint'(d.upper_raw);
    raw[2] = longint'(d.lower_raw);
    off_p  = !d.offset_button_level;
    rng_p  = !d.range_button_level;
    ang[0] = (raw[0] - offs[0]) >>> 2;
    ang[1] = sat(raw[1] - offs[1]);
    ang[2] = sat(raw[2] - offs[2]);
    for (int i = 0; i < 3; i++) n[i] = scale_to_unit(ang[i], lows[i], highs[i]);
    n[3] = scale_to_unit(0, claw_lo, claw_hi);
    case (jarn_pkg::cmd_t'(d.cmd))
      jarn_pkg::CMD_CAPTURE: for (int i = 0; i < 3; i++) offs[i] = raw[i];
      jarn_pkg::CMD_TOGGLE: begin
        learn_on = !learn_on;
        if (learn_on) restart_ranges(ang);
      end
      default: ;
    endcase
    if (learn_on)
      for (int i = 0; i < 3; i++) begin
        if (ang[i] < lows[i]) lows[i] = ang[i];
        if (ang[i] > highs[i]) highs[i] = ang[i];
      end
    if (off_p && !off_was) for (int i = 0; i < 3; i++) offs[i] = raw[i];
    off_was = off_p;
    if (rng_p && !rng_was) begin
      learn_on = !learn_on;
      if (learn_on) restart_ranges(ang);
    end
    rng_was = rng_p;
    r.norm_shoulder   = NW'(n[0]);
    r.norm_upper      = NW'(n[1]);
    r.norm_lower      = NW'(n[2]);
    r.norm_claw       = NW'(n[3]);
    r.shoulder_angle  = AW'(ang[0]);
    r.upper_angle_neg = AW'(sat(-ang[1]));
    r.lower_angle     = AW'(ang[2]);
    r.armed           = !d.armed_level;
    r.learning        = learn_on;
    return r;
  endfunction

  function automatic jarn_pkg::in_t mk(jarn_pkg::cmd_t c, longint s, longint u, longint l,
                                       bit a, bit o, bit g);
    jarn_pkg::in_t d;
    d.cmd = c;
    d.shoulder_raw = AW'(s);
    d.upper_raw = AW'(u);
    d.lower_raw = AW'(l);
    d.armed_level = a;
    d.offset_button_level = o;
    d.range_button_level = g;
    return d;
  endfunction

  task automatic send_item(jarn_pkg::in_t d, bit typed, jarn_pkg::out_t typed_exp);
    jarn_pkg::out_t p;
    if (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    p = normalise_item(d);
    norm_q.push_back(typed ? typed_exp : p);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, longint v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= AW'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == jarn_pkg::CFG_CLAW_LOW) claw_lo = longint'(cfg_data);
    else if (idx == jarn_pkg::CFG_CLAW_HIGH) claw_hi = longint'(cfg_data);
    @(posedge clk);
  endtask

  function automatic longint rnd_angle();
    case ($urandom_range(4))
      0: return longint'(signed'(AW'($urandom)));
      1: return SAT_HI - $urandom_range(3);
      2: return SAT_LO + $urandom_range(3);
      default: return longint'($urandom_range(60000)) - 30000;
    endcase
  endfunction

  function automatic jarn_pkg::in_t rnd_item();
    int   k;
    jarn_pkg::cmd_t c;
    k = $urandom_range(99);
    c = (k < 80) ? jarn_pkg::CMD_NONE : (k < 88) ? jarn_pkg::CMD_CAPTURE :
        (k < 97) ? jarn_pkg::CMD_TOGGLE : jarn_pkg::CMD_SPARE;
    return mk(c, rnd_angle(), rnd_angle(), rnd_angle(), 1'($urandom_range(1)),
              $urandom_range(99) >= 12, $urandom_range(99) >= 10);
  endfunction

  task automatic note(string f, longint e, longint a);
    if (e != a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d got %0d", f, e, a);
    end
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    int hold;
    jarn_pkg::out_t e;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (norm_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item");
        end else begin
          e = norm_q.pop_front();
          note("norm_shoulder", e.norm_shoulder, out_data.norm_shoulder);
          note("norm_upper", e.norm_upper, out_data.norm_upper);
          note("norm_lower", e.norm_lower, out_data.norm_lower);
          note("norm_claw", e.norm_claw, out_data.norm_claw);
          note("shoulder_angle", e.shoulder_angle, out_data.shoulder_angle);
          note("upper_angle_neg", e.upper_angle_neg, out_data.upper_angle_neg);
          note("lower_angle", e.lower_angle, out_data.lower_angle);
          note("armed", e.armed, out_data.armed);
          note("learning", e.learning, out_data.learning);
        end
        if (results_seen == 300) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else
        out_ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    jarn_pkg::in_t  dir_in [$];
    jarn_pkg::out_t dir_exp [$];
    bit   dir_typed [$];
    jarn_pkg::out_t z, ex;
    longint lo_set [NUM_PHASES];
    longint hi_set [NUM_PHASES];

    lo_set = '{SAT_LO, 0, 20000, SAT_LO, -3};
    hi_set = '{SAT_HI, 0, -20000, SAT_LO + 1, 5};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    for (int i = 0; i < 3; i++) begin
      offs[i] = 0;
      lows[i] = -longint'(jarn_pkg::RANGE_DEFAULT);
      highs[i] = longint'(jarn_pkg::RANGE_DEFAULT);
    end
    learn_on = 0; off_was = 0; rng_was = 0;
    claw_lo = -longint'(jarn_pkg::ONE_Q);
    claw_hi = longint'(jarn_pkg::ONE_Q);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z = '0;
    // after reset: everything centred, armed
    ex = z; ex.armed = 1'b1;
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 0, 0, 0, 0, 1, 1)); dir_exp.push_back(ex);
    dir_typed.push_back(1);
    // extremes: clamp to range ends, upper negation saturates
    ex = z;
    ex.norm_shoulder = 16384; ex.norm_upper = -16384; ex.norm_lower = 16384;
    ex.shoulder_angle = 131071; ex.upper_angle_neg = AW'(SAT_HI);
    ex.lower_angle = AW'(SAT_HI);
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, SAT_HI, SAT_LO, SAT_HI, 1, 1, 1));
    dir_exp.push_back(ex);
    dir_typed.push_back(1);
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, SAT_LO, SAT_HI, SAT_LO, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_CAPTURE, SAT_HI, SAT_HI, SAT_LO, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, SAT_LO, SAT_LO, SAT_HI, 1, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, -1, 3, -5, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_CAPTURE, 1000, -2000, 3000, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_TOGGLE, 1200, -2100, 3300, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 9000, -9000, 1000, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, -7000, 5000, 8000, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 2000, 0, 4000, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_SPARE, 1500, 100, -100, 1, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_TOGGLE, 0, 0, 0, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 800, 800, 800, 0, 0, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 900, 900, 900, 0, 0, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 100, 100, 100, 0, 1, 0));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 5000, -5000, 300, 0, 1, 0));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, -5000, 5000, -300, 0, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_TOGGLE, 10, 20, 30, 0, 0, 0));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 40, 50, 60, 1, 1, 1));
    dir_in.push_back(mk(jarn_pkg::CMD_NONE, 40, 50, 60, 1, 1, 0));
    while (dir_typed.size() < dir_in.size()) begin
      dir_typed.push_back(0);
      dir_exp.push_back(z);
    end
    for (int i = 0; i < dir_in.size(); i++) send_item(dir_in[i], dir_typed[i], dir_exp[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == 2) write_reg(CFG_SPARE_A, $urandom);
      if (ph == 3) write_reg(CFG_SPARE_B, $urandom);
      write_reg(jarn_pkg::CFG_CLAW_LOW, lo_set[ph]);
      write_reg(jarn_pkg::CFG_CLAW_HIGH, hi_set[ph]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_item(rnd_item(), 0, z);
    end
    drain();
    if (mismatches == 0 && norm_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
src/jarn_pkg.sv
src/jarn_lane.sv
src/joint_angle_range_normalizer_core.sv
sim/testbench.sv
